@@ rtl/assert_macros.svh @@
// Assertion macros shared by the rank transform RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rtu_pkg.sv @@
// Package for the rank transform unit: widths, defaults, FSM and control types.
// No dependencies; used by rtu_select and rank_transform_unit.
package rtu_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int VALUE_W   = 32;
   localparam int RANK_W    = 6;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SETTLE,
      ST_COMMIT,
      ST_EMIT_READ,
      ST_EMIT_SEND
   } state_type;

   // Control from the sequencer to the minimum selector
   typedef struct packed {
      logic clear;    // start a new selection pass
      logic compare;  // read data for a candidate is valid this cycle
      logic taken;    // candidate already holds a rank
   } sel_ctl_type;

endpackage

@@ rtl/rtu_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies; instantiated for the value store and the rank store.
module rtu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/rtu_select.sv @@
// Running minimum selector: keeps the smallest untaken value seen in a pass.
// Depends on rtu_pkg for the control struct and value width.
module rtu_select #(
   parameter int DEPTH = rtu_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rtu_pkg::sel_ctl_type          ctl,
   input  logic [$clog2(DEPTH)-1:0]      cand_idx,
   input  logic signed [rtu_pkg::VALUE_W-1:0] cand_value,
   output logic [$clog2(DEPTH)-1:0]      best_idx,
   output logic                          found
);

   localparam int AW = $clog2(DEPTH);

   logic                              found_ff, found_in;
   logic [AW-1:0]                     best_idx_ff, best_idx_in;
   logic signed [rtu_pkg::VALUE_W-1:0] best_val_ff, best_val_in;
   logic                              take;

   // strict less keeps the lowest position on ties
   assign take = ctl.compare && !ctl.taken && (!found_ff || (cand_value < best_val_ff));

   always_comb begin
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_val_in = best_val_ff;
      priority if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in    = 1'b1;
         best_idx_in = cand_idx;
         best_val_in = cand_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
   end

   assign best_idx = best_idx_ff;
   assign found    = found_ff;

endmodule

@@ rtl/rank_transform_unit.sv @@
// Rank transform unit: top level with sequencer, value and rank stores.
// Depends on rtu_pkg, rtu_ram, rtu_select and assert_macros.svh.
// Load: one item per cycle while idle; the last item starts ranking, intake stalls until done.
// Ranking: n passes over the value RAM (one read port), each a scan of the n items, then settle and commit.
// Output: n items, each a rank RAM read, then a send that holds until the response is taken.
// Reset clears state, fill count, overflow flag and taken bits; RAM contents are left as is.
`include "assert_macros.svh"

module rank_transform_unit #(
   parameter int DEPTH = rtu_pkg::DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [rtu_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rtu_pkg::RANK_W-1:0]         rsp_rank,
   output logic                               rsp_overflow,
   output logic                               rsp_last_out
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rtu_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic                 ovf_ff, ovf_in;
   logic [DEPTH-1:0]     taken_ff, taken_in;
   logic [AW-1:0]        scan_idx_ff, scan_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]        rank_ff, rank_in;
   logic [AW-1:0]        emit_idx_ff, emit_idx_in;

   logic                 req_accept, rsp_accept, store_ok;
   logic [AW-1:0]        last_idx;
   logic                 val_wr_en, val_rd_en, rank_wr_en, rank_rd_en;
   logic [rtu_pkg::VALUE_W-1:0] val_rd_data;
   logic [AW-1:0]        rank_rd_data;
   logic [AW-1:0]        best_idx;
   logic                 sel_found;
   rtu_pkg::sel_ctl_type sel_ctl;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign store_ok   = fill_ff < CW'(DEPTH);
   assign last_idx   = AW'(fill_ff - CW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtu_pkg::ST_LOAD: begin
            if (req_accept && req_last) state_in = rtu_pkg::ST_SCAN;
         end
         rtu_pkg::ST_SCAN: begin
            if (scan_idx_ff == last_idx) state_in = rtu_pkg::ST_SETTLE;
         end
         rtu_pkg::ST_SETTLE: begin
            state_in = rtu_pkg::ST_COMMIT;
         end
         rtu_pkg::ST_COMMIT: begin
            state_in = (rank_ff == last_idx) ? rtu_pkg::ST_EMIT_READ : rtu_pkg::ST_SCAN;
         end
         rtu_pkg::ST_EMIT_READ: begin
            state_in = rtu_pkg::ST_EMIT_SEND;
         end
         rtu_pkg::ST_EMIT_SEND: begin
            if (rsp_accept) begin
               state_in = (emit_idx_ff == last_idx) ? rtu_pkg::ST_LOAD
                                                    : rtu_pkg::ST_EMIT_READ;
            end
         end
         default: state_in = rtu_pkg::ST_LOAD;
      endcase
   end

   // FSM outputs; the phases keep RAM reads and writes apart, so no forwarding
   always_comb begin
      req_stall       = (state_ff != rtu_pkg::ST_LOAD);
      rsp_valid       = (state_ff == rtu_pkg::ST_EMIT_SEND);
      val_rd_en       = (state_ff == rtu_pkg::ST_SCAN);
      rank_wr_en      = (state_ff == rtu_pkg::ST_COMMIT);
      rank_rd_en      = (state_ff == rtu_pkg::ST_EMIT_READ);
      val_wr_en       = (state_ff == rtu_pkg::ST_LOAD) && req_valid && store_ok;
      sel_ctl.clear   = (state_ff == rtu_pkg::ST_COMMIT);
      sel_ctl.compare = cmp_vld_ff;
      sel_ctl.taken   = taken_ff[cmp_idx_ff];
   end

   // datapath counters and flags
   always_comb begin
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      taken_in    = taken_ff;
      scan_idx_in = scan_idx_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = scan_idx_ff;
      rank_in     = rank_ff;
      emit_idx_in = emit_idx_ff;
      unique case (state_ff)
         rtu_pkg::ST_LOAD: begin
            if (req_accept) begin
               if (store_ok) fill_in = fill_ff + CW'(1);
               else          ovf_in  = 1'b1;
               scan_idx_in = '0;
               rank_in     = '0;
            end
         end
         rtu_pkg::ST_SCAN: begin
            cmp_vld_in  = 1'b1;
            scan_idx_in = (scan_idx_ff == last_idx) ? '0 : scan_idx_ff + AW'(1);
         end
         rtu_pkg::ST_SETTLE: begin
         end
         rtu_pkg::ST_COMMIT: begin
            taken_in[best_idx] = 1'b1;
            rank_in            = rank_ff + AW'(1);
            emit_idx_in        = '0;
         end
         rtu_pkg::ST_EMIT_READ: begin
         end
         rtu_pkg::ST_EMIT_SEND: begin
            if (rsp_accept) begin
               emit_idx_in = emit_idx_ff + AW'(1);
               if (emit_idx_ff == last_idx) begin
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  taken_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rtu_pkg::ST_LOAD;
         fill_ff    <= '0;
         ovf_ff     <= 1'b0;
         taken_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         ovf_ff     <= ovf_in;
         taken_ff   <= taken_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // indices, no reset needed
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      rank_ff     <= rank_in;
      emit_idx_ff <= emit_idx_in;
   end

   // value store
   rtu_ram #(
      .WIDTH (rtu_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock      (clock),
      .wr_en      (val_wr_en),
      .wr_addr    (AW'(fill_ff)),
      .wr_data    (req_value),
      .rd_en      (val_rd_en),
      .rd_addr    (scan_idx_ff),
      .rd_data_ff (val_rd_data)
   );

   // rank store
   rtu_ram #(
      .WIDTH (AW),
      .DEPTH (DEPTH)
   ) u_rank_ram (
      .clock      (clock),
      .wr_en      (rank_wr_en),
      .wr_addr    (best_idx),
      .wr_data    (rank_ff),
      .rd_en      (rank_rd_en),
      .rd_addr    (emit_idx_ff),
      .rd_data_ff (rank_rd_data)
   );

   // minimum search over one pass
   rtu_select #(
      .DEPTH (DEPTH)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sel_ctl),
      .cand_idx   (cmp_idx_ff),
      .cand_value ($signed(val_rd_data)),
      .best_idx   (best_idx),
      .found      (sel_found)
   );

   assign rsp_rank     = rtu_pkg::RANK_W'(rank_rd_data);
   assign rsp_overflow = ovf_ff;
   assign rsp_last_out = (emit_idx_ff == last_idx);

   // checks
   `ASSERT_IMPL(a_commit_found, clock, reset, state_ff == rtu_pkg::ST_COMMIT, sel_found, "commit without a selected item")
   `ASSERT_NEXT(a_last_starts, clock, reset, req_accept && req_last, state_ff == rtu_pkg::ST_SCAN, "last item did not start ranking")
   `ASSERT_NEXT(a_end_clears, clock, reset, rsp_accept && rsp_last_out, (fill_ff == '0) && (taken_ff == '0) && !ovf_ff, "set state not cleared after final item")
   `ASSERT_IMPL(a_load_untaken, clock, reset, state_ff == rtu_pkg::ST_LOAD, taken_ff == '0, "taken bits set while loading")

endmodule
